@@ hdl/atcm_pkg.sv @@
// Package for the three-colour annealing move unit.
// Opcodes, colour codes and shared field widths; no dependencies.
package atcm_pkg;

    typedef enum logic [1:0] {
        OP_FORCE   = 2'd0,
        OP_ADD     = 2'd1,
        OP_RECOLOR = 2'd2,
        OP_SWAP    = 2'd3
    } opcode_t;

    localparam int VID_BITS   = 10;
    localparam int ERR_BITS   = 31;
    localparam int COLORS     = 3;
    localparam logic [1:0] COLOR_NONE = 2'd3;

endpackage

@@ hdl/atcm_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module atcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read at one address; the read returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hdl/anneal_three_color_move_unit.sv @@
// Three-colour annealing move unit: top level with sequencer and shared adder.
// Depends on atcm_pkg and atcm_ram.
//
// One word in, one word out. Each item runs through a sequencer that uses a
// single shared add/subtract unit over single-port memories. After reset a
// clearing pass over every sum address zeroes the colour, degree and sum
// memories before the first word is taken. For each neighbour the sequencer
// reads the list entry, then reads and writes the neighbour's sum for the old
// colour and again for the new one, all on the single sum port. A result is
// held in an output register until taken; the next word is accepted only when
// the previous result has gone.
module anneal_three_color_move_unit
    import atcm_pkg::*;
#(
    parameter int VERTICES    = 1024,
    parameter int MAX_DEGREE  = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], first_vertex[11:2], second_vertex[21:12], new_color[23:22],
    // edge_weight[39:24], uphill_allowance[70:40], zero fill to 72
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], total_error[31:1], neighbors_touched[39:32], status[40],
    // zero fill to 48
    output logic [47:0] m_axis_tdata
);

    localparam int VB   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int DB   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DGB  = $clog2(MAX_DEGREE + 1);
    localparam int SUMB = WEIGHT_BITS + DGB + 1;
    localparam int SB   = $clog2(VERTICES * 3);
    localparam int LB   = VB + DB;
    localparam int AB   = 34;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_GET_A, S_GET_B, S_SUM1, S_SUM2,
        S_SUM3, S_SUM4, S_DECIDE, S_ADD_W1, S_ADD_W2, S_ADD_S1, S_ADD_S2,
        S_ADD_S3, S_ADD_S4, S_NB_LIST, S_NB_RD1, S_NB_WR1, S_NB_RD2, S_NB_WR2,
        S_COLOR1, S_COLOR2, S_DONE
    } state_t;

    state_t state_reg;

    // Captured input word
    logic [1:0]             op_reg;
    logic [VID_BITS-1:0]    va_reg, vb_reg;
    logic [1:0]             nc_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [ERR_BITS-1:0]    allow_reg;

    logic [1:0]     ca_reg, cb_reg;
    logic [DGB-1:0] da_reg, db_reg;
    logic signed [AB-1:0] acc_reg;
    logic [ERR_BITS-1:0]  err_reg;
    logic [7:0]     touched_reg;
    logic [SB-1:0]  clr_reg;
    // neighbour walk
    logic           side_reg;
    logic [DGB-1:0] k_reg;
    logic [1:0]     from_reg, to_reg;
    logic [VID_BITS-1:0] nb_reg;
    logic [WEIGHT_BITS-1:0] nw_reg;

    logic out_valid_reg, out_acc_reg, out_status_reg;
    logic [7:0] out_touched_reg;

    // Memory ports
    logic            col_we, deg_we, sum_we, lst_we;
    logic [VB-1:0]   col_addr, deg_addr;
    logic [1:0]      col_wdata, col_rdata;
    logic [DGB-1:0]  deg_wdata, deg_rdata;
    logic [SB-1:0]   sum_addr;
    logic [SUMB-1:0] sum_wdata, sum_rdata;
    logic [LB-1:0]   lst_addr;
    logic [VID_BITS+WEIGHT_BITS-1:0] lst_wdata, lst_rdata;

    atcm_ram #(.WIDTH(2), .DEPTH(VERTICES)) u_color (
        .clk(clk), .we(col_we), .addr(col_addr), .wdata(col_wdata), .rdata(col_rdata));
    atcm_ram #(.WIDTH(DGB), .DEPTH(VERTICES)) u_degree (
        .clk(clk), .we(deg_we), .addr(deg_addr), .wdata(deg_wdata), .rdata(deg_rdata));
    atcm_ram #(.WIDTH(SUMB), .DEPTH(VERTICES * 3)) u_sums (
        .clk(clk), .we(sum_we), .addr(sum_addr), .wdata(sum_wdata), .rdata(sum_rdata));
    atcm_ram #(.WIDTH(VID_BITS + WEIGHT_BITS), .DEPTH(VERTICES * MAX_DEGREE)) u_list (
        .clk(clk), .we(lst_we), .addr(lst_addr), .wdata(lst_wdata), .rdata(lst_rdata));

    // Input field views
    logic [1:0]             in_op, in_nc;
    logic [VID_BITS-1:0]    in_a, in_b;
    assign in_op = s_axis_tdata[1:0];
    assign in_a  = s_axis_tdata[11:2];
    assign in_b  = s_axis_tdata[21:12];
    assign in_nc = s_axis_tdata[23:22];

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_status_reg, out_touched_reg, err_reg, out_acc_reg};

    // Sum address: vertex*3 + colour
    function automatic logic [SB-1:0] sidx(input logic [VID_BITS-1:0] v,
                                           input logic [1:0] c);
        logic [SB+1:0] t;
        t = (SB+2)'(v) * (SB+2)'(COLORS) + (SB+2)'(c);
        return t[SB-1:0];
    endfunction

    function automatic logic [LB-1:0] lidx(input logic [VID_BITS-1:0] v,
                                           input logic [DGB-1:0] k);
        logic [LB+VID_BITS:0] t;
        t = (LB+VID_BITS+1)'(v) * (LB+VID_BITS+1)'(MAX_DEGREE) + (LB+VID_BITS+1)'(k);
        return t[LB-1:0];
    endfunction

    // Shared adder: accumulator plus or minus signed operand
    logic signed [AB-1:0] add_b, add_y;
    logic                 add_sub;
    assign add_y = add_sub ? (acc_reg - add_b) : (acc_reg + add_b);

    logic [VID_BITS-1:0] walk_v;
    assign walk_v = side_reg ? vb_reg : va_reg;

    // Saturated error from accumulator
    logic [ERR_BITS-1:0] acc_sat;
    always_comb
    begin
        if (acc_reg < 0)
            acc_sat = '0;
        else if (acc_reg > AB'(2147483647))
            acc_sat = {ERR_BITS{1'b1}};
        else
            acc_sat = acc_reg[ERR_BITS-1:0];
    end

    logic in_range_a, in_range_b;
    assign in_range_a = 32'(va_reg) < VERTICES;
    assign in_range_b = 32'(vb_reg) < VERTICES;

    // Memory control
    always_comb
    begin
        col_we = 1'b0; deg_we = 1'b0; sum_we = 1'b0; lst_we = 1'b0;
        col_addr = va_reg[VB-1:0]; deg_addr = va_reg[VB-1:0];
        col_wdata = '0; deg_wdata = '0;
        sum_addr = sidx(va_reg, ca_reg); sum_wdata = '0;
        lst_addr = lidx(walk_v, k_reg);
        lst_wdata = {w_reg, vb_reg};
        add_b = '0; add_sub = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                col_we = 32'(clr_reg) < VERTICES;
                deg_we = col_we;
                sum_we = 1'b1;
                col_addr = clr_reg[VB-1:0];
                deg_addr = clr_reg[VB-1:0];
                sum_addr = clr_reg;
            end
            S_RD_B:
            begin
                col_addr = vb_reg[VB-1:0];
                deg_addr = vb_reg[VB-1:0];
            end
            // second vertex colour is still on the read port here
            S_SUM1: sum_addr = (op_reg == OP_SWAP) ? sidx(va_reg, col_rdata)
                                                    : sidx(va_reg, nc_reg);
            S_SUM2:
            begin
                sum_addr = sidx(va_reg, ca_reg);
                add_b = AB'(sum_rdata);
            end
            S_SUM3: sum_addr = sidx(vb_reg, ca_reg);
            S_SUM4:
            begin
                sum_addr = sidx(vb_reg, cb_reg);
                add_b = AB'(sum_rdata);
            end
            S_GET_A:
            begin
                add_b = AB'(sum_rdata);
                add_sub = 1'b1;
            end
            S_DECIDE:
            begin
                add_b = AB'(sum_rdata);
                add_sub = 1'b1;
            end
            S_ADD_W1:
            begin
                lst_we = 1'b1;
                lst_addr = lidx(va_reg, da_reg);
                lst_wdata = {w_reg, vb_reg};
                deg_we = 1'b1;
                deg_wdata = da_reg + 1'b1;
                sum_addr = sidx(va_reg, cb_reg);
            end
            S_ADD_W2:
            begin
                lst_we = 1'b1;
                lst_addr = lidx(vb_reg, db_reg);
                lst_wdata = {w_reg, va_reg};
                deg_we = 1'b1;
                deg_addr = vb_reg[VB-1:0];
                deg_wdata = db_reg + 1'b1;
                sum_addr = sidx(va_reg, cb_reg);
            end
            S_ADD_S1:
            begin
                sum_we = 1'b1;
                sum_addr = sidx(va_reg, cb_reg);
                sum_wdata = sum_rdata + SUMB'(w_reg);
            end
            S_ADD_S2: sum_addr = sidx(vb_reg, ca_reg);
            S_ADD_S3:
            begin
                sum_addr = sidx(vb_reg, ca_reg);
            end
            S_ADD_S4:
            begin
                sum_we = 1'b1;
                sum_addr = sidx(vb_reg, ca_reg);
                sum_wdata = sum_rdata + SUMB'(w_reg);
            end
            // neighbour id comes straight off the list port
            S_NB_RD1: sum_addr = sidx(lst_rdata[VID_BITS-1:0], from_reg);
            S_NB_WR1:
            begin
                sum_we = 1'b1;
                sum_addr = sidx(nb_reg, from_reg);
                sum_wdata = sum_rdata - SUMB'(nw_reg);
            end
            S_NB_RD2: sum_addr = sidx(nb_reg, to_reg);
            S_NB_WR2:
            begin
                sum_we = 1'b1;
                sum_addr = sidx(nb_reg, to_reg);
                sum_wdata = sum_rdata + SUMB'(nw_reg);
            end
            S_COLOR1:
            begin
                col_we = 1'b1;
                col_wdata = (op_reg == OP_SWAP) ? cb_reg : nc_reg;
            end
            S_COLOR2:
            begin
                col_we = 1'b1;
                col_addr = vb_reg[VB-1:0];
                col_wdata = ca_reg;
            end
            default: ;
        endcase
    end

    // Sequencer, registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == VERTICES * 3 - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg    <= in_op;
                        va_reg    <= in_a;
                        vb_reg    <= in_b;
                        nc_reg    <= in_nc;
                        w_reg     <= s_axis_tdata[24 +: WEIGHT_BITS];
                        allow_reg <= s_axis_tdata[70:40];
                        out_acc_reg     <= 1'b0;
                        out_status_reg  <= 1'b0;
                        out_touched_reg <= '0;
                        touched_reg     <= '0;
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A:
                begin
                    // ignore out-of-range vertices and colour code three
                    if (!in_range_a ||
                        ((op_reg == OP_FORCE || op_reg == OP_RECOLOR) && nc_reg == COLOR_NONE) ||
                        ((op_reg == OP_ADD || op_reg == OP_SWAP) && !in_range_b))
                    begin
                        out_status_reg <= (op_reg == OP_ADD);
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    ca_reg <= col_rdata;
                    da_reg <= deg_rdata;
                    state_reg <= S_SUM1;
                end
                S_SUM1:
                begin
                    cb_reg <= col_rdata;
                    db_reg <= deg_rdata;
                    acc_reg <= '0;
                    if (op_reg == OP_ADD)
                    begin
                        if (va_reg == vb_reg || 32'(da_reg) >= MAX_DEGREE ||
                            32'(deg_rdata) >= MAX_DEGREE)
                        begin
                            out_status_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_ADD_W1;
                    end
                    else if (op_reg != OP_SWAP && ca_reg == nc_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_SUM2;
                end
                S_SUM2:
                begin
                    acc_reg <= add_y;
                    state_reg <= S_GET_A;
                end
                S_GET_A:
                begin
                    acc_reg <= add_y;
                    state_reg <= S_GET_B;
                end
                S_GET_B:
                begin
                    state_reg <= (op_reg == OP_SWAP) ? S_SUM3 : S_DECIDE;
                end
                S_SUM3:
                begin
                    if (ca_reg != cb_reg)
                        acc_reg <= acc_reg - AB'({w_reg, 1'b0});
                    state_reg <= S_SUM4;
                end
                S_SUM4:
                begin
                    acc_reg <= add_y;
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    logic signed [AB-1:0] delta;
                    delta = (op_reg == OP_SWAP) ? add_y : acc_reg;
                    if (op_reg == OP_FORCE || delta < $signed(AB'(allow_reg)))
                    begin
                        acc_reg  <= AB'(err_reg) + delta;
                        out_acc_reg <= 1'b1;
                        side_reg <= 1'b0;
                        k_reg    <= '0;
                        from_reg <= ca_reg;
                        to_reg   <= (op_reg == OP_SWAP) ? cb_reg : nc_reg;
                        state_reg <= S_NB_LIST;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_ADD_W1:
                begin
                    acc_reg <= AB'(err_reg) + ((ca_reg == cb_reg) ? AB'(w_reg) : AB'(0));
                    state_reg <= S_ADD_W2;
                end
                S_ADD_W2: state_reg <= S_ADD_S1;
                S_ADD_S1: state_reg <= S_ADD_S2;
                S_ADD_S2: state_reg <= S_ADD_S3;
                S_ADD_S3: state_reg <= S_ADD_S4;
                S_ADD_S4:
                begin
                    err_reg <= acc_sat;
                    out_acc_reg <= 1'b1;
                    out_touched_reg <= 8'd2;
                    state_reg <= S_DONE;
                end
                S_NB_LIST:
                begin
                    if (k_reg == (side_reg ? db_reg : da_reg))
                    begin
                        if (op_reg == OP_SWAP && !side_reg)
                        begin
                            side_reg <= 1'b1;
                            k_reg    <= '0;
                            from_reg <= cb_reg;
                            to_reg   <= ca_reg;
                        end
                        else
                            state_reg <= S_COLOR1;
                    end
                    else
                        state_reg <= S_NB_RD1;
                end
                S_NB_RD1:
                begin
                    nb_reg <= lst_rdata[VID_BITS-1:0];
                    nw_reg <= lst_rdata[VID_BITS +: WEIGHT_BITS];
                    state_reg <= S_NB_WR1;
                end
                S_NB_WR1: state_reg <= S_NB_RD2;
                S_NB_RD2: state_reg <= S_NB_WR2;
                S_NB_WR2:
                begin
                    k_reg <= k_reg + 1'b1;
                    touched_reg <= touched_reg + 1'b1;
                    state_reg <= S_NB_LIST;
                end
                S_COLOR1:
                begin
                    err_reg <= acc_sat;
                    out_touched_reg <= touched_reg;
                    state_reg <= (op_reg == OP_SWAP) ? S_COLOR2 : S_DONE;
                end
                S_COLOR2: state_reg <= S_DONE;
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/atcm_checker.sv @@
// Checker for the three-colour annealing move unit: watches both streams,
// predicts each result word and compares it. Depends on atcm_pkg.
module atcm_checker
    import atcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV  = 1024;
    localparam int DEG = 64;

    typedef struct packed {
        logic        status;
        logic [7:0]  touched;
        logic [30:0] total_error;
        logic        accepted;
    } move_result_t;

    logic [1:0]  colour [NV];
    longint      colour_sum [NV*3];
    int          degree [NV];
    int          nbr_id [NV*DEG];
    longint      nbr_w [NV*DEG];
    longint      err_total;
    move_result_t result_q [$];

    initial
    begin
        for (int i = 0; i < NV; i++)
        begin
            colour[i] = 0;
            degree[i] = 0;
        end
        for (int i = 0; i < NV*3; i++)
            colour_sum[i] = 0;
        err_total = 0;
        fail_count = 0;
    end

    assign pending_count = result_q.size();

    function automatic void clamp_error(longint e);
        if (e < 0) e = 0;
        if (e > 64'd2147483647) e = 64'd2147483647;
        err_total = e;
    endfunction

    // Move vertex v's weight in every neighbour's sums from one colour to another
    function automatic int move_sums(int v, int fc, int tc);
        for (int k = 0; k < degree[v]; k++)
        begin
            colour_sum[nbr_id[v*DEG+k]*3+fc] -= nbr_w[v*DEG+k];
            colour_sum[nbr_id[v*DEG+k]*3+tc] += nbr_w[v*DEG+k];
        end
        return degree[v];
    endfunction

    function automatic move_result_t predict_move(logic [71:0] d);
        opcode_t     op;
        int          a, b, nc, oc, cu, cv, t;
        longint      w, allow, delta, ew;
        logic        acc, st;
        move_result_t r;
        op    = opcode_t'(d[1:0]);
        a     = d[11:2];
        b     = d[21:12];
        nc    = d[23:22];
        w     = d[39:24];
        allow = d[70:40];
        acc = 0; st = 0; t = 0;
        case (op)
            OP_FORCE, OP_RECOLOR:
            begin
                if (nc != COLOR_NONE)
                begin
                    oc = colour[a];
                    if (oc != nc)
                    begin
                        delta = colour_sum[a*3+nc] - colour_sum[a*3+oc];
                        if (op == OP_FORCE || delta < allow)
                        begin
                            clamp_error(err_total + delta);
                            t = move_sums(a, oc, nc);
                            colour[a] = nc;
                            acc = 1;
                        end
                    end
                end
            end
            OP_ADD:
            begin
                if (a == b || degree[a] >= DEG || degree[b] >= DEG)
                    st = 1;
                else
                begin
                    nbr_id[a*DEG+degree[a]] = b;
                    nbr_w[a*DEG+degree[a]]  = w;
                    nbr_id[b*DEG+degree[b]] = a;
                    nbr_w[b*DEG+degree[b]]  = w;
                    degree[a]++;
                    degree[b]++;
                    colour_sum[a*3+colour[b]] += w;
                    colour_sum[b*3+colour[a]] += w;
                    if (colour[a] == colour[b])
                        clamp_error(err_total + w);
                    t = 2;
                    acc = 1;
                end
            end
            default:
            begin
                cu = colour[a];
                cv = colour[b];
                ew = (cu == cv) ? 0 : w;
                delta = -colour_sum[a*3+cu] + colour_sum[a*3+cv]
                        - colour_sum[b*3+cv] + colour_sum[b*3+cu] - 2*ew;
                if (delta < allow)
                begin
                    clamp_error(err_total + delta);
                    t = move_sums(a, cu, cv);
                    t += move_sums(b, cv, cu);
                    colour[a] = cv;
                    colour[b] = cu;
                    acc = 1;
                end
            end
        endcase
        r.accepted    = acc;
        r.total_error = err_total[30:0];
        r.touched     = t[7:0];
        r.status      = st;
        return r;
    endfunction

    // Predict on each accepted input word, compare each output word
    always @(posedge clk)
    begin
        move_result_t got, exp_r;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            result_q.push_back(predict_move(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[40:0];
            if (result_q.size() == 0)
            begin
                $error("unexpected result word %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (got.accepted !== exp_r.accepted)
                begin
                    $error("accepted: expected %0d actual %0d", exp_r.accepted, got.accepted);
                    fail_count++;
                end
                if (got.total_error !== exp_r.total_error)
                begin
                    $error("total_error: expected %0d actual %0d",
                           exp_r.total_error, got.total_error);
                    fail_count++;
                end
                if (got.touched !== exp_r.touched)
                begin
                    $error("neighbors_touched: expected %0d actual %0d",
                           exp_r.touched, got.touched);
                    fail_count++;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    fail_count++;
                end
                if (m_axis_tdata[47:41] !== 7'd0)
                begin
                    $error("fill: expected 0 actual %h", m_axis_tdata[47:41]);
                    fail_count++;
                end
            end
        end
    end
endmodule

@@ tb/tb.sv @@
// Testbench top for the three-colour annealing move unit: clock, reset,
// stimulus with idling phases and verdict. Depends on atcm_pkg, atcm_checker.
module tb
    import atcm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;

    anneal_three_color_move_unit dut (.*);

    atcm_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin
        #200ms;
        $display("FAIL anneal_three_color_move_unit");
        $finish;
    end

    // Receiver: random stall, plus one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_off <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [71:0] pack_word(opcode_t op, int a, int b, int c,
                                              int w, logic [30:0] allow);
        logic [71:0] d;
        d = '0;
        d[1:0]   = op;
        d[11:2]  = 10'(a);
        d[21:12] = 10'(b);
        d[23:22] = 2'(c);
        d[39:24] = 16'(w);
        d[70:40] = allow;
        return d;
    endfunction

    // Offer one word, idling first at the current rate, and wait for acceptance
    task automatic send_word(logic [71:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Mostly small vertex set so that edges and colours interact
    function automatic logic [71:0] random_word();
        opcode_t op;
        int a, b, c, r;
        logic [30:0] allow;
        r = $urandom_range(99);
        op = (r < 30) ? OP_ADD : (r < 60) ? OP_RECOLOR : (r < 85) ? OP_SWAP : OP_FORCE;
        if ($urandom_range(9) == 0)
        begin
            a = $urandom_range(1023);
            b = $urandom_range(1023);
        end
        else
        begin
            a = $urandom_range(15);
            b = $urandom_range(15);
        end
        c = ($urandom_range(19) == 0) ? 3 : $urandom_range(2);
        r = $urandom_range(3);
        allow = (r == 0) ? 31'd0 : (r == 1) ? 31'($urandom_range(70000))
              : (r == 2) ? 31'h7FFFFFFF : 31'($urandom);
        return pack_word(op, a, b, c, $urandom_range(65535), allow);
    endfunction

    initial
    begin
        int cnt;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every opcode, special cases
        send_word(pack_word(OP_ADD, 0, 1023, 0, 65535, 0));
        send_word(pack_word(OP_ADD, 5, 5, 0, 100, 0));
        send_word(pack_word(OP_ADD, 0, 1, 1, 0, 0));
        send_word(pack_word(OP_RECOLOR, 0, 0, 0, 0, 31'h7FFFFFFF));
        send_word(pack_word(OP_RECOLOR, 0, 0, 3, 0, 31'h7FFFFFFF));
        send_word(pack_word(OP_RECOLOR, 0, 0, 2, 0, 0));
        send_word(pack_word(OP_FORCE, 1023, 0, 1, 0, 0));
        send_word(pack_word(OP_FORCE, 1023, 0, 0, 0, 0));
        send_word(pack_word(OP_SWAP, 0, 1023, 0, 65535, 0));
        send_word(pack_word(OP_SWAP, 0, 1, 0, 7, 0));
        send_word(pack_word(OP_SWAP, 0, 1, 0, 7, 1));
        send_word(pack_word(OP_SWAP, 0, 1023, 0, 12345, 31'h7FFFFFFF));
        send_word(pack_word(OP_FORCE, 2, 0, 2, 0, 0));
        send_word(pack_word(OP_RECOLOR, 1023, 0, 2, 0, 31'h7FFFFFFF));
        // Fill one list, then overflow it
        for (int i = 0; i < 65; i++)
            send_word(pack_word(OP_ADD, 7, 8 + i, 0, 65535, 0));
        send_word(pack_word(OP_ADD, 8, 7, 0, 1, 0));
        send_word(pack_word(OP_FORCE, 7, 0, 1, 0, 0));
        send_word(pack_word(OP_SWAP, 7, 8, 0, 65535, 31'h7FFFFFFF));

        // Random in four idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 38) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 59 : 38) : 0;
            if (ph == 2)
                hold_req <= 1'b1;
            for (int i = 0; i < 240; i++)
                send_word(random_word());
        end
        s_axis_tvalid <= 1'b0;

        cnt = 0;
        while (pending_count != 0 && cnt < 100000)
        begin
            @(posedge clk);
            cnt++;
        end
        repeat (500) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS anneal_three_color_move_unit");
        else
            $display("FAIL anneal_three_color_move_unit");
        $finish;
    end
endmodule
